>>> src/rtcm3crc_pkg.sv
`default_nettype none

package rtcm3crc_pkg;

  localparam logic [7:0]  PREAMBLE = 8'hD3;
  localparam logic [23:0] CRC_POLY = 24'h864CFB;

  // Frame phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_RESV = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_CRC  = 5'b10000
  } phase_e;

  // One result beat
  typedef struct packed {
    logic [7:0]  byte_echo;
    logic        in_frame;
    logic [10:0] byte_index;
    logic        frame_end;
    logic        crc_ok;
    logic [9:0]  payload_length;
    logic        frame_dropped;
    logic [15:0] good_frames;
  } result_t;

  // CRC-24Q, one byte, MSB first, no reflection
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    logic        msb;
    c = crc ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      msb = c[23];
      c   = {c[22:0], 1'b0};
      if (msb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/rtcm3crc_core.sv
`default_nettype none

module rtcm3crc_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic [7:0]            rx_byte_i,
  output      rtcm3crc_pkg::result_t res_o
);

  rtcm3crc_pkg::phase_e phase_q, phase_d;
  logic [10:0] byte_count_q, byte_count_d;
  logic [9:0]  frame_length_q, frame_length_d;
  logic [23:0] crc_q, crc_d;
  logic [23:0] rx_crc_q, rx_crc_d;
  logic [15:0] good_q, good_d;

  logic [23:0] crc_step;
  logic [10:0] cnt_inc;
  logic [9:0]  len_new;
  logic [23:0] rx_crc_new;
  logic        pay_done;
  logic        crc_done;
  logic        crc_match;

  assign crc_step   = rtcm3crc_pkg::crc24q_byte(crc_q, rx_byte_i);
  assign cnt_inc    = byte_count_q + 11'd1;
  assign len_new    = {frame_length_q[9:8], rx_byte_i};
  assign rx_crc_new = {rx_crc_q[15:0], rx_byte_i};
  assign pay_done   = {1'b0, cnt_inc} >= ({2'b00, frame_length_q} + 12'd3);
  assign crc_done   = {1'b0, cnt_inc} >= ({2'b00, frame_length_q} + 12'd6);
  assign crc_match  = (rx_crc_new == crc_q);

  always_comb begin
    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    frame_length_d = frame_length_q;
    crc_d          = crc_q;
    rx_crc_d       = rx_crc_q;
    good_d         = good_q;

    res_o                = '0;
    res_o.byte_echo      = rx_byte_i;

    case (phase_q)
      rtcm3crc_pkg::PH_RESV: begin
        if (rx_byte_i[7:2] == 6'd0) begin
          res_o.in_frame   = 1'b1;
          res_o.byte_index = byte_count_q;
          frame_length_d   = {rx_byte_i[1:0], 8'h00};
          crc_d            = crc_step;
          byte_count_d     = cnt_inc;
          phase_d          = rtcm3crc_pkg::PH_LEN;
        end else begin
          res_o.frame_dropped = 1'b1;
          phase_d             = rtcm3crc_pkg::PH_HUNT;
        end
      end
      rtcm3crc_pkg::PH_LEN: begin
        res_o.in_frame   = 1'b1;
        res_o.byte_index = byte_count_q;
        frame_length_d   = len_new;
        crc_d            = crc_step;
        byte_count_d     = cnt_inc;
        if (len_new == 10'd0) begin
          res_o.frame_dropped = 1'b1;
          phase_d             = rtcm3crc_pkg::PH_HUNT;
        end else begin
          phase_d = rtcm3crc_pkg::PH_PAY;
        end
      end
      rtcm3crc_pkg::PH_PAY: begin
        res_o.in_frame   = 1'b1;
        res_o.byte_index = byte_count_q;
        crc_d            = crc_step;
        byte_count_d     = cnt_inc;
        if (pay_done) begin
          rx_crc_d = '0;
          phase_d  = rtcm3crc_pkg::PH_CRC;
        end
      end
      rtcm3crc_pkg::PH_CRC: begin
        res_o.in_frame   = 1'b1;
        res_o.byte_index = byte_count_q;
        rx_crc_d         = rx_crc_new;
        byte_count_d     = cnt_inc;
        if (crc_done) begin
          res_o.frame_end = 1'b1;
          res_o.crc_ok    = crc_match;
          if (crc_match) begin
            good_d = good_q + 16'd1;
          end
          phase_d = rtcm3crc_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_d = rtcm3crc_pkg::PH_HUNT;
        if (rx_byte_i == rtcm3crc_pkg::PREAMBLE) begin
          res_o.in_frame = 1'b1;
          frame_length_d = '0;
          rx_crc_d       = '0;
          crc_d          = rtcm3crc_pkg::crc24q_byte(24'h000000, rx_byte_i);
          byte_count_d   = 11'd1;
          phase_d        = rtcm3crc_pkg::PH_RESV;
        end
      end
    endcase

    res_o.payload_length = frame_length_d;
    res_o.good_frames    = good_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= rtcm3crc_pkg::PH_HUNT;
      byte_count_q   <= '0;
      frame_length_q <= '0;
      crc_q          <= '0;
      rx_crc_q       <= '0;
      good_q         <= '0;
    end else if (fire_i) begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      frame_length_q <= frame_length_d;
      crc_q          <= crc_d;
      rx_crc_q       <= rx_crc_d;
      good_q         <= good_d;
    end
  end

`ifndef SYNTH
  a_phase_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_good_only_on_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(good_q))
    else $error("good count moved without a beat");

  a_hunt_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == rtcm3crc_pkg::PH_HUNT && rx_byte_i != rtcm3crc_pkg::PREAMBLE
    |=> phase_q == rtcm3crc_pkg::PH_HUNT)
    else $error("left hunt without a preamble");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= 11'd1029)
    else $error("frame position out of range");
`endif

endmodule

`default_nettype wire

>>> src/rtcm3_frame_crc24_checker_top.sv
`default_nettype none

// RTCM 3 frame checker with CRC-24Q. Feed received bytes in one beat per
// byte; every byte comes back out once, in order, tagged with its position in
// the candidate frame (preamble 0xD3 is position 0), the decoded payload
// length, a drop mark when the reserved bits are nonzero or the length is
// zero, and on the last of the three CRC bytes a frame-end mark with the
// pass/fail verdict. good_frames counts passing frames and wraps at 65536.
// Throughput is one byte per clock while out_stall_i is low; each byte passes
// through the input register, then one bytewise CRC step plus phase update
// into the result register. A stall on the output side backs up into
// in_stall_o once both registers hold a beat.

module rtcm3_frame_crc24_checker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  rx_byte_i,

  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  byte_echo_o,
  output      logic        in_frame_o,
  output      logic [10:0] byte_index_o,
  output      logic        frame_end_o,
  output      logic        crc_ok_o,
  output      logic [9:0]  payload_length_o,
  output      logic        frame_dropped_o,
  output      logic [15:0] good_frames_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] rx_byte_q;

  // result register
  logic                  out_valid_q;
  rtcm3crc_pkg::result_t res_q;
  rtcm3crc_pkg::result_t res_d;

  logic out_adv;   // result register may load
  logic proc_fire; // beat moves from input to result register
  logic in_adv;    // input register may load

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign proc_fire  = in_valid_q && out_adv;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  // frame tracking and CRC, state commits only on a processed beat
  rtcm3crc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (proc_fire),
    .rx_byte_i (rx_byte_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_echo_o      = res_q.byte_echo;
  assign in_frame_o       = res_q.in_frame;
  assign byte_index_o     = res_q.byte_index;
  assign frame_end_o      = res_q.frame_end;
  assign crc_ok_o         = res_q.crc_ok;
  assign payload_length_o = res_q.payload_length;
  assign frame_dropped_o  = res_q.frame_dropped;
  assign good_frames_o    = res_q.good_frames;

`ifndef SYNTH
  a_stall_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held beat");

  a_fire_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> out_valid_o)
    else $error("processed beat lost before result register");

  a_end_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (res_d.frame_end || res_d.crc_ok) |-> res_d.in_frame && res_d.frame_end)
    else $error("verdict outside a frame");
`endif

endmodule

`default_nettype wire
